FILE: sv/lpse_pkg.sv
// ----------------------------------------------------------------------------
// lpse_pkg
// Types, register map and scaling helper for the led pulse stream encoder.
// ----------------------------------------------------------------------------
package lpse_pkg;

  localparam int unsigned MaxPixels = 1024;

  typedef enum logic [2:0] {
    FUNC_ORDERED_RGB = 3'd0,
    FUNC_RAW_RGB     = 3'd1,
    FUNC_POWER_RGB   = 3'd2,
    FUNC_RAW_RGBW    = 3'd3,
    FUNC_POWER_RGBW  = 3'd4,
    FUNC_SINGLE_BYTE = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    REG_BRIGHTNESS      = 3'd0,
    REG_RED_SLOT        = 3'd1,
    REG_GREEN_SLOT      = 3'd2,
    REG_BLUE_SLOT       = 3'd3,
    REG_ONE_HIGH_TICKS  = 3'd4,
    REG_ONE_LOW_TICKS   = 3'd5,
    REG_ZERO_HIGH_TICKS = 3'd6,
    REG_ZERO_LOW_TICKS  = 3'd7
  } reg_e;

  localparam logic [7:0] BrightnessRst    = 8'd255;
  localparam logic [1:0] RedSlotRst       = 2'd1;
  localparam logic [1:0] GreenSlotRst     = 2'd0;
  localparam logic [1:0] BlueSlotRst      = 2'd2;
  localparam logic [7:0] OneHighTicksRst  = 8'd8;
  localparam logic [7:0] OneLowTicksRst   = 8'd4;
  localparam logic [7:0] ZeroHighTicksRst = 8'd4;
  localparam logic [7:0] ZeroLowTicksRst  = 8'd8;

  typedef struct packed {
    logic [2:0] func;
    logic [9:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic [7:0] power;
  } pix_t;

  typedef struct packed {
    logic [9:0] out_pixel;
    logic [4:0] bit_position;
    logic [7:0] high_ticks;
    logic [7:0] low_ticks;
    logic       last_bit;
  } pulse_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic [1:0] red_slot;
    logic [1:0] green_slot;
    logic [1:0] blue_slot;
    logic [7:0] one_high_ticks;
    logic [7:0] one_low_ticks;
    logic [7:0] zero_high_ticks;
    logic [7:0] zero_low_ticks;
  } cfg_t;

  typedef struct packed {
    logic [31:0] pattern;
    logic [5:0]  nbits;
    logic [9:0]  pixel;
  } pat_t;

  // floor(v * f / 255) without a divider
  function automatic logic [7:0] scale8(logic [7:0] v, logic [7:0] f);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = v * f;
    sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

FILE: sv/lpse_if.sv
// ----------------------------------------------------------------------------
// lpse_pix_if / lpse_pulse_if
// Valid/ready channels for pixel items and pulse descriptors.
// ----------------------------------------------------------------------------
interface lpse_pix_if;
  import lpse_pkg::*;
  logic valid;
  logic ready;
  pix_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lpse_pulse_if;
  import lpse_pkg::*;
  logic   valid;
  logic   ready;
  pulse_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/lpse_cfg_regs.sv
// ----------------------------------------------------------------------------
// lpse_cfg_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module lpse_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [7:0]    cfg_wdata_i,
  output lpse_pkg::cfg_t cfg_o
);
  import lpse_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness      <= BrightnessRst;
      cfg_q.red_slot        <= RedSlotRst;
      cfg_q.green_slot      <= GreenSlotRst;
      cfg_q.blue_slot       <= BlueSlotRst;
      cfg_q.one_high_ticks  <= OneHighTicksRst;
      cfg_q.one_low_ticks   <= OneLowTicksRst;
      cfg_q.zero_high_ticks <= ZeroHighTicksRst;
      cfg_q.zero_low_ticks  <= ZeroLowTicksRst;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_BRIGHTNESS:      cfg_q.brightness      <= cfg_wdata_i;
        REG_RED_SLOT:        cfg_q.red_slot        <= cfg_wdata_i[1:0];
        REG_GREEN_SLOT:      cfg_q.green_slot      <= cfg_wdata_i[1:0];
        REG_BLUE_SLOT:       cfg_q.blue_slot       <= cfg_wdata_i[1:0];
        REG_ONE_HIGH_TICKS:  cfg_q.one_high_ticks  <= cfg_wdata_i;
        REG_ONE_LOW_TICKS:   cfg_q.one_low_ticks   <= cfg_wdata_i;
        REG_ZERO_HIGH_TICKS: cfg_q.zero_high_ticks <= cfg_wdata_i;
        REG_ZERO_LOW_TICKS:  cfg_q.zero_low_ticks  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/lpse_pattern.sv
// ----------------------------------------------------------------------------
// lpse_pattern
// Builds the msb-aligned bit pattern and bit count of one pixel.
// ----------------------------------------------------------------------------
module lpse_pattern (
  input  lpse_pkg::pix_t pix_i,
  input  lpse_pkg::cfg_t cfg_i,
  output lpse_pkg::pat_t pat_o
);
  import lpse_pkg::*;

  logic [7:0] factor;
  logic [7:0] sr, sg, sb, sw;
  logic [7:0] slot [3];

  assign factor = (func_e'(pix_i.func) == FUNC_ORDERED_RGB) ? cfg_i.brightness
                                                            : pix_i.power;
  assign sr = scale8(pix_i.red, factor);
  assign sg = scale8(pix_i.green, factor);
  assign sb = scale8(pix_i.blue, factor);
  assign sw = scale8(pix_i.white, factor);

  // later colour wins on a shared slot, slot three is dropped
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      slot[i] = 8'd0;
      if (cfg_i.red_slot == 2'(i)) slot[i] = sr;
      if (cfg_i.green_slot == 2'(i)) slot[i] = sg;
      if (cfg_i.blue_slot == 2'(i)) slot[i] = sb;
    end
  end

  always_comb begin
    pat_o.pixel = pix_i.pixel_index;
    unique case (func_e'(pix_i.func))
      FUNC_ORDERED_RGB: begin
        pat_o.pattern = {slot[0], slot[1], slot[2], 8'd0};
        pat_o.nbits   = 6'd24;
      end
      FUNC_RAW_RGB: begin
        pat_o.pattern = {pix_i.red, pix_i.green, pix_i.blue, 8'd0};
        pat_o.nbits   = 6'd24;
      end
      FUNC_POWER_RGB: begin
        pat_o.pattern = {sr, sg, sb, 8'd0};
        pat_o.nbits   = 6'd24;
      end
      FUNC_RAW_RGBW: begin
        pat_o.pattern = {pix_i.red, pix_i.green, pix_i.blue, pix_i.white};
        pat_o.nbits   = 6'd32;
      end
      FUNC_POWER_RGBW: begin
        pat_o.pattern = {sr, sg, sb, sw};
        pat_o.nbits   = 6'd32;
      end
      FUNC_SINGLE_BYTE: begin
        pat_o.pattern = {pix_i.red, 24'd0};
        pat_o.nbits   = 6'd8;
      end
      default: begin
        pat_o.pattern = 32'd0;
        pat_o.nbits   = 6'd0;
      end
    endcase
  end

endmodule

FILE: sv/lpse_serializer.sv
// ----------------------------------------------------------------------------
// lpse_serializer
// Shifts a pattern out msb first into an output register, one pulse beat per
// cycle while that register is free to take it.
// ----------------------------------------------------------------------------
module lpse_serializer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lpse_pkg::cfg_t cfg_i,
  input  logic           pat_valid_i,
  input  lpse_pkg::pat_t pat_i,
  output logic           pat_take_o,
  lpse_pulse_if.source   pulse_o
);
  import lpse_pkg::*;

  logic [31:0] shift_q, shift_d;
  logic [5:0]  left_q, left_d;
  logic [4:0]  pos_q, pos_d;
  logic [9:0]  pix_q, pix_d;
  logic        out_vld_q, out_vld_d;
  pulse_t      out_q, out_d;
  logic        out_free, emit, load, one;

  assign out_free   = !out_vld_q || pulse_o.ready;
  assign emit       = (left_q != 6'd0) && out_free;
  assign load       = pat_valid_i && ((left_q == 6'd0) || ((left_q == 6'd1) && emit));
  assign pat_take_o = load;
  assign one        = shift_q[31];

  always_comb begin
    shift_d   = shift_q;
    left_d    = left_q;
    pos_d     = pos_q;
    pix_d     = pix_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !pulse_o.ready;
    if (emit) begin
      out_vld_d          = 1'b1;
      out_d.out_pixel    = pix_q;
      out_d.bit_position = pos_q;
      out_d.high_ticks   = one ? cfg_i.one_high_ticks : cfg_i.zero_high_ticks;
      out_d.low_ticks    = one ? cfg_i.one_low_ticks : cfg_i.zero_low_ticks;
      out_d.last_bit     = (left_q == 6'd1);
      shift_d            = {shift_q[30:0], 1'b0};
      left_d             = left_q - 6'd1;
      pos_d              = pos_q + 5'd1;
    end
    if (load) begin
      shift_d = pat_i.pattern;
      left_d  = pat_i.nbits;
      pos_d   = 5'd0;
      pix_d   = pat_i.pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= 6'd0;
      out_vld_q <= 1'b0;
    end else begin
      left_q    <= left_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    pos_q   <= pos_d;
    pix_q   <= pix_d;
    out_q   <= out_d;
  end

  assign pulse_o.valid   = out_vld_q;
  assign pulse_o.payload = out_q;

endmodule

FILE: sv/led_pulse_stream_encoder.sv
// ----------------------------------------------------------------------------
// led_pulse_stream_encoder
// Turns one pixel per input beat into a run of high/low pulse descriptors.
// ----------------------------------------------------------------------------
// pix_i carries one pixel per beat; pulse_o returns one pulse descriptor per
// beat, msb of the pixel pattern first, with last_bit set on the final pulse.
// Single byte pixels give 8 pulses, rgb modes 24 and rgbw modes 32. Items
// with an unused func code or an index at or above the pixel limit are
// taken and dropped without any pulse.
// A pixel's first pulse passes the input, shift and output registers in order.
// The shift register sends one pulse per cycle while pulse_o takes them; the
// next pixel is loaded as the last pulse leaves and pixels may arrive back
// to back, one held in the input register meanwhile.
// When pulse_o stalls, the output register holds its beat, the shifter
// stops and pix_i drops ready once the input register is full.
// Reset empties all stages and loads the default brightness, slot order
// and pulse timings. Write configuration through cfg_we_i only while idle.
// ----------------------------------------------------------------------------
module led_pulse_stream_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  lpse_pix_if.sink    pix_i,
  lpse_pulse_if.source pulse_o
);
  import lpse_pkg::*;

  cfg_t  cfg;
  pat_t  pat;
  pix_t  pix_q;
  logic  pix_vld_q;
  logic  pat_take;
  logic  item_ok;
  logic  in_fire;

  lpse_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign pix_i.ready = !pix_vld_q || pat_take;
  assign in_fire     = pix_i.valid && pix_i.ready;
  assign item_ok     = (pix_i.payload.func <= FUNC_SINGLE_BYTE) &&
                       ({7'd0, pix_i.payload.pixel_index} < 17'(MaxPixels));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
    end else if (pix_i.ready) begin
      pix_vld_q <= in_fire && item_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pix_q <= pix_i.payload;
    end
  end

  lpse_pattern u_pattern (
    .pix_i (pix_q),
    .cfg_i (cfg),
    .pat_o (pat)
  );

  lpse_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pat_valid_i (pix_vld_q),
    .pat_i       (pat),
    .pat_take_o  (pat_take),
    .pulse_o     (pulse_o)
  );

endmodule

FILE: bench/led_pulse_stream_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_pulse_stream_encoder_tb
// Drives pixel beats through the encoder and checks every pulse descriptor.
// A short table of hand-picked pixels comes first, then several phases of
// random pixels under different brightness, slot orders and pulse timings.
// Each accepted pixel is expanded into its expected pulse run and every
// pulse beat is compared in order. Both channels idle at random, and once
// the pulse side holds off long enough for the pixel side to back up.
// ----------------------------------------------------------------------------
module led_pulse_stream_encoder_tb;
  import lpse_pkg::*;

  localparam logic [2:0]  FuncSpareLo   = 3'd6;
  localparam logic [2:0]  FuncSpareHi   = 3'd7;
  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned ItemsPerPhase = 88;
  localparam int unsigned NumPhases     = 5;
  localparam int unsigned MaxReports    = 10;

  typedef struct {
    pix_t        pix;
    bit          known;
    logic [31:0] pattern;
    int unsigned nbits;
  } pix_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_idx_i   = REG_BRIGHTNESS;
  logic [7:0] cfg_wdata_i = 8'd0;

  lpse_pix_if   pix_if ();
  lpse_pulse_if pulse_if ();

  led_pulse_stream_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .pulse_o     (pulse_if)
  );

  cfg_t        enc_cfg;
  pulse_t      pending_pulses[$];
  pix_row_t    pixel_table[$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left    = 0;
  bit          jitter_en    = 1'b1;
  bit          hold_req     = 1'b0;
  bit          hold_taken   = 1'b0;

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] dim(logic [7:0] v, logic [7:0] f);
    int unsigned prod;
    prod = int'(v) * int'(f);
    return 8'(prod / 255);
  endfunction

  function automatic void pixel_bits(input pix_t p, input cfg_t c,
                                     output logic [31:0] pat, output int unsigned n);
    logic [7:0] slot [4];
    for (int i = 0; i < 4; i++) slot[i] = 8'd0;
    pat = '0;
    n   = 0;
    case (p.func)
      FUNC_ORDERED_RGB: begin
        slot[c.red_slot]   = dim(p.red, c.brightness);
        slot[c.green_slot] = dim(p.green, c.brightness);
        slot[c.blue_slot]  = dim(p.blue, c.brightness);
        pat = {8'd0, slot[0], slot[1], slot[2]};
        n   = 24;
      end
      FUNC_RAW_RGB: begin
        pat = {8'd0, p.red, p.green, p.blue};
        n   = 24;
      end
      FUNC_POWER_RGB: begin
        pat = {8'd0, dim(p.red, p.power), dim(p.green, p.power), dim(p.blue, p.power)};
        n   = 24;
      end
      FUNC_RAW_RGBW: begin
        pat = {p.red, p.green, p.blue, p.white};
        n   = 32;
      end
      FUNC_POWER_RGBW: begin
        pat = {dim(p.red, p.power), dim(p.green, p.power),
               dim(p.blue, p.power), dim(p.white, p.power)};
        n   = 32;
      end
      FUNC_SINGLE_BYTE: begin
        pat = {24'd0, p.red};
        n   = 8;
      end
      default: n = 0;
    endcase
  endfunction

  function automatic void queue_pulses(logic [31:0] pat, int unsigned n, logic [9:0] pixel);
    logic [31:0] sh;
    pulse_t      pl;
    sh = (n == 0) ? 32'd0 : pat << (32 - n);
    for (int unsigned k = 0; k < n; k++) begin
      pl.out_pixel    = pixel;
      pl.bit_position = k[4:0];
      pl.high_ticks   = sh[31] ? enc_cfg.one_high_ticks : enc_cfg.zero_high_ticks;
      pl.low_ticks    = sh[31] ? enc_cfg.one_low_ticks : enc_cfg.zero_low_ticks;
      pl.last_bit     = (k + 1 == n);
      pending_pulses.push_back(pl);
      sh = sh << 1;
    end
  endfunction

  function automatic pix_row_t make_row(logic [2:0] f, logic [9:0] pixel, logic [7:0] r,
                                        logic [7:0] g, logic [7:0] b, logic [7:0] w,
                                        logic [7:0] pw, bit known, logic [31:0] pat,
                                        int unsigned n);
    pix_row_t row;
    row.pix     = '{func: f, pixel_index: pixel, red: r, green: g, blue: b,
                    white: w, power: pw};
    row.known   = known;
    row.pattern = pat;
    row.nbits   = n;
    return row;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_row_t random_row();
    logic [2:0] f;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 18) f = 3'(pick % 6);
    else f = $urandom_range(0, 1) ? FuncSpareHi : FuncSpareLo;
    return make_row(f, 10'($urandom_range(0, 1023)), rand_byte(), rand_byte(), rand_byte(),
                    rand_byte(), rand_byte(), 1'b0, 32'd0, 0);
  endfunction

  function automatic cfg_t phase_cfg(int unsigned ph);
    cfg_t c;
    int unsigned r, g;
    r = $urandom_range(0, 2);
    g = (r + 1 + $urandom_range(0, 1)) % 3;
    c.brightness      = 8'($urandom_range(0, 255));
    c.red_slot        = 2'(r);
    c.green_slot      = 2'(g);
    c.blue_slot       = 2'(3 - r - g);
    c.one_high_ticks  = 8'($urandom_range(1, 255));
    c.one_low_ticks   = 8'($urandom_range(1, 255));
    c.zero_high_ticks = 8'($urandom_range(1, 255));
    c.zero_low_ticks  = 8'($urandom_range(1, 255));
    case (ph)
      1: c = '{8'd0, 2'd2, 2'd1, 2'd0, 8'd255, 8'd1, 8'd1, 8'd255};
      // red dropped, green and blue collide on slot zero
      2: c = '{8'd128, 2'd3, 2'd0, 2'd0, 8'd0, 8'd255, 8'd255, 8'd0};
      3: begin
        c.brightness = 8'd255;
        c.red_slot   = 2'd3;
        c.green_slot = 2'd3;
        c.blue_slot  = 2'd3;
      end
      4: begin
        c.red_slot        = 2'($urandom_range(0, 3));
        c.green_slot      = 2'($urandom_range(0, 3));
        c.blue_slot       = 2'($urandom_range(0, 3));
        c.one_high_ticks  = 8'($urandom_range(0, 255));
        c.zero_low_ticks  = 8'($urandom_range(0, 255));
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic write_cfg(input cfg_t c);
    reg_e order [8] = '{REG_BRIGHTNESS, REG_RED_SLOT, REG_GREEN_SLOT, REG_BLUE_SLOT,
                        REG_ONE_HIGH_TICKS, REG_ONE_LOW_TICKS, REG_ZERO_HIGH_TICKS,
                        REG_ZERO_LOW_TICKS};
    logic [7:0] val;
    foreach (order[i]) begin
      case (order[i])
        REG_BRIGHTNESS:      val = c.brightness;
        REG_RED_SLOT:        val = {6'd0, c.red_slot};
        REG_GREEN_SLOT:      val = {6'd0, c.green_slot};
        REG_BLUE_SLOT:       val = {6'd0, c.blue_slot};
        REG_ONE_HIGH_TICKS:  val = c.one_high_ticks;
        REG_ONE_LOW_TICKS:   val = c.one_low_ticks;
        REG_ZERO_HIGH_TICKS: val = c.zero_high_ticks;
        default:             val = c.zero_low_ticks;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= order[i];
      cfg_wdata_i <= val;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    enc_cfg = c;
  endtask

  task automatic send_pixel(input pix_row_t row);
    logic [31:0] pat;
    int unsigned n;
    while (jitter_en && $urandom_range(0, 99) < 15) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid   <= 1'b1;
    pix_if.payload <= row.pix;
    do @(posedge clk_i); while (!pix_if.ready);
    if (row.known) begin
      pat = row.pattern;
      n   = row.nbits;
    end else begin
      pixel_bits(row.pix, enc_cfg, pat, n);
    end
    queue_pulses(pat, n, row.pix.pixel_index);
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void check_pulse(pulse_t got);
    pulse_t want;
    if (pending_pulses.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) $display("unexpected pulse beat %h", got);
    end else begin
      want = pending_pulses.pop_front();
      if (want.out_pixel !== got.out_pixel || want.bit_position !== got.bit_position ||
          want.high_ticks !== got.high_ticks || want.low_ticks !== got.low_ticks ||
          want.last_bit !== got.last_bit) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("pulse mismatch: exp pix %0d bit %0d hi %0d lo %0d last %0d",
                   want.out_pixel, want.bit_position, want.high_ticks, want.low_ticks,
                   want.last_bit);
          $display("                got pix %0d bit %0d hi %0d lo %0d last %0d",
                   got.out_pixel, got.bit_position, got.high_ticks, got.low_ticks,
                   got.last_bit);
        end
      end
    end
  endfunction

  // pulse side: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pulse_if.valid && pulse_if.ready) check_pulse(pulse_if.payload);
      if (hold_req && !hold_taken) begin
        hold_taken      <= 1'b1;
        hold_left       <= HoldCycles;
        pulse_if.ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left       <= hold_left - 1;
        pulse_if.ready  <= 1'b0;
      end else begin
        pulse_if.ready  <= !(jitter_en && $urandom_range(0, 99) < 15);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_if.valid && pix_if.ready) || (pulse_if.valid && pulse_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("led_pulse_stream_encoder_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    pix_if.valid   = 1'b0;
    pix_if.payload = '0;
    pulse_if.ready = 1'b0;
    enc_cfg = '{BrightnessRst, RedSlotRst, GreenSlotRst, BlueSlotRst, OneHighTicksRst,
                OneLowTicksRst, ZeroHighTicksRst, ZeroLowTicksRst};

    // default order puts green, red, blue at full brightness
    pixel_table.push_back(make_row(FUNC_SINGLE_BYTE, 10'd0, 8'ha5, 8'h00, 8'h00, 8'h00,
                                   8'h00, 1'b1, 32'h0000_00a5, 8));
    pixel_table.push_back(make_row(FUNC_SINGLE_BYTE, 10'd1023, 8'h00, 8'hff, 8'hff, 8'hff,
                                   8'hff, 1'b1, 32'h0000_0000, 8));
    pixel_table.push_back(make_row(FUNC_SINGLE_BYTE, 10'd512, 8'hff, 8'h00, 8'h00, 8'h00,
                                   8'h00, 1'b1, 32'h0000_00ff, 8));
    pixel_table.push_back(make_row(FUNC_RAW_RGB, 10'd5, 8'hff, 8'h00, 8'h80, 8'h11,
                                   8'h22, 1'b1, 32'h00ff_0080, 24));
    pixel_table.push_back(make_row(FUNC_RAW_RGBW, 10'd1022, 8'hff, 8'hff, 8'hff, 8'hff,
                                   8'h00, 1'b1, 32'hffff_ffff, 32));
    pixel_table.push_back(make_row(FUNC_RAW_RGBW, 10'd341, 8'h00, 8'h00, 8'h00, 8'h00,
                                   8'hff, 1'b1, 32'h0000_0000, 32));
    pixel_table.push_back(make_row(FUNC_RAW_RGBW, 10'd682, 8'h80, 8'h01, 8'h7f, 8'hfe,
                                   8'h55, 1'b1, 32'h8001_7ffe, 32));
    pixel_table.push_back(make_row(FUNC_ORDERED_RGB, 10'd7, 8'h12, 8'h34, 8'h56, 8'hff,
                                   8'h00, 1'b1, 32'h0034_1256, 24));
    pixel_table.push_back(make_row(FUNC_ORDERED_RGB, 10'd8, 8'hff, 8'h00, 8'hff, 8'h00,
                                   8'h00, 1'b1, 32'h0000_ffff, 24));
    pixel_table.push_back(make_row(FUNC_POWER_RGB, 10'd9, 8'hff, 8'hff, 8'hff, 8'hff,
                                   8'h00, 1'b1, 32'h0000_0000, 24));
    pixel_table.push_back(make_row(FUNC_POWER_RGB, 10'd10, 8'hab, 8'hcd, 8'hef, 8'h00,
                                   8'hff, 1'b1, 32'h00ab_cdef, 24));
    pixel_table.push_back(make_row(FUNC_POWER_RGBW, 10'd11, 8'h01, 8'h02, 8'h03, 8'h04,
                                   8'hff, 1'b1, 32'h0102_0304, 32));
    pixel_table.push_back(make_row(FUNC_POWER_RGBW, 10'd12, 8'hff, 8'hff, 8'hff, 8'hff,
                                   8'h00, 1'b1, 32'h0000_0000, 32));
    pixel_table.push_back(make_row(FUNC_POWER_RGB, 10'd13, 8'hff, 8'h80, 8'h01, 8'h00,
                                   8'h80, 1'b0, 32'd0, 0));
    pixel_table.push_back(make_row(FUNC_POWER_RGBW, 10'd14, 8'hff, 8'hfe, 8'h01, 8'h80,
                                   8'hfe, 1'b0, 32'd0, 0));
    pixel_table.push_back(make_row(FUNC_POWER_RGBW, 10'd15, 8'hff, 8'hff, 8'hff, 8'hff,
                                   8'h01, 1'b0, 32'd0, 0));
    // unused func codes are swallowed without pulses
    pixel_table.push_back(make_row(FuncSpareLo, 10'd16, 8'hff, 8'hff, 8'hff, 8'hff,
                                   8'hff, 1'b1, 32'd0, 0));
    pixel_table.push_back(make_row(FuncSpareHi, 10'd17, 8'h5a, 8'h5a, 8'h5a, 8'h5a,
                                   8'h5a, 1'b1, 32'd0, 0));
    pixel_table.push_back(make_row(FUNC_ORDERED_RGB, 10'd18, 8'hc3, 8'h3c, 8'h99, 8'h00,
                                   8'h00, 1'b0, 32'd0, 0));
    pixel_table.push_back(make_row(FUNC_SINGLE_BYTE, 10'd19, 8'h5a, 8'h00, 8'h00, 8'h00,
                                   8'h00, 1'b0, 32'd0, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pixel_table[i]) send_pixel(pixel_table[i]);
    drain();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      write_cfg(phase_cfg(ph));
      jitter_en <= (ph != 1);
      for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
        if (ph == 2 && i == 10) hold_req <= 1'b1;
        send_pixel(random_row());
      end
      drain();
    end

    repeat (SettleCycles * 4) @(posedge clk_i);
    if (mismatches == 0 && pending_pulses.size() == 0) begin
      $display("led_pulse_stream_encoder_tb OK");
    end else begin
      $display("led_pulse_stream_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule
